### hdl/e2q_pkg.sv
// Shared types, stage indexes and fixed constants of the Euler-to-quaternion core.
package e2q_pkg;

    // Register stages inside one angle lane.
    localparam int ST_SPLIT    = 0;
    localparam int ST_MODEST   = 1;
    localparam int ST_MODFIX   = 2;
    localparam int ST_PHASEHI  = 3;
    localparam int ST_DIVA_EST = 4;
    localparam int ST_DIVA_FIX = 5;
    localparam int ST_DIVB_EST = 6;
    localparam int ST_PHASE    = 7;
    localparam int ST_RAD      = 8;
    localparam int ST_COMP     = 9;
    localparam int ST_SQR      = 10;
    localparam int ST_ITER     = 11;
    localparam int SIN_TERMS   = 7;
    localparam int ST_SIN      = ST_ITER + 3 * SIN_TERMS;
    localparam int ST_MAP      = ST_SIN + 1;
    localparam int LANE_STAGES = ST_MAP + 1;

    // Axis codes.
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // A 720 degree turn is 45 times a power of two.
    localparam logic [5:0]  TURN_DIV = 6'd45;
    localparam logic [5:0]  TURN_REM = 6'((64'd1 << 32) % TURN_DIV);
    localparam logic [31:0] DIV_Q    = 32'((64'd1 << 32) / TURN_DIV);
    localparam logic [11:0] DIV_M1   = 12'((64'd1 << 17) / TURN_DIV);
    localparam logic [16:0] DIV_M2   = 17'((64'd1 << 22) / TURN_DIV);

    // Q30 constants.
    localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;
    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;

    // Elementary quaternion of one lane, Q30.
    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_quat;

    // Product component, Q30 with headroom.
    typedef logic signed [32:0] t_q30;

    // Sign of term j in component i of a Hamilton product (partner index is i xor j).
    function automatic logic hm_neg(input int i, input int j);
        logic neg;
        neg = (i == 0 && j != 0) || (i == 1 && j == 3) ||
              (i == 2 && j == 1) || (i == 3 && j == 2);
        return neg;
    endfunction

endpackage

### hdl/e2q_lane.sv
// One angle lane: angle reduction, half-angle sine and cosine, and the elementary quaternion.
module e2q_lane #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic [e2q_pkg::LANE_STAGES-1:0]     i_ld,
    input  logic signed [31:0]                  i_angle,
    input  logic [1:0]                          i_axis,
    output e2q_pkg::t_quat                      o_quat
);

    localparam int SH  = ANGLE_FRAC_BITS + 4;
    localparam int HW  = 28 - ANGLE_FRAC_BITS;
    localparam int NW  = HW + 5;
    localparam int LOW = 28 - ANGLE_FRAC_BITS;
    localparam logic [NW-1:0] OFS = NW'(e2q_pkg::TURN_DIV) << (HW - 1);
    localparam logic [NW-6:0] M0  = (NW-5)'((64'd1 << NW) / e2q_pkg::TURN_DIV);
    localparam int NI = e2q_pkg::SIN_TERMS;

    // Axis code and quadrant travel alongside the data.
    logic [1:0] r_axis [0:e2q_pkg::ST_MAP-1];
    logic [1:0] r_quad [e2q_pkg::ST_RAD:e2q_pkg::ST_MAP-1];

    always_ff @(posedge i_clk) begin
        if (i_ld[e2q_pkg::ST_SPLIT]) begin
            r_axis[0] <= i_axis;
        end
        for (int j = 1; j < e2q_pkg::ST_MAP; j++) begin
            if (i_ld[j]) begin
                r_axis[j] <= r_axis[j-1];
            end
        end
    end

    // Angle reduction modulo 720 degrees and the phase in 2^-32 turns.
    logic [NW-1:0]   r_n0, r_n0b;
    logic [SH-1:0]   r_lo0, r_lo1, r_lo2;
    logic [NW-6:0]   r_q0e;
    logic [5:0]      r_hm2, r_hm3, r_hm4, r_hm5;
    logic [32:0]     r_n1, r_n1b;
    logic [11:0]     r_q1e, r_q1, r_q1b;
    logic [21:0]     r_n2, r_n2b;
    logic [16:0]     r_q2e;
    logic [31:0]     r_hq;
    logic [31:0]     r_p;

    logic [2*NW-6:0] w_p0;
    logic [NW-1:0]   w_r0, w_hm;
    logic [28:0]     w_p1;
    logic [16:0]     w_r1, w_r1f;
    logic [11:0]     w_q1;
    logic [38:0]     w_p2;
    logic [21:0]     w_r2, w_r2f;
    logic [16:0]     w_q2;

    assign w_p0 = r_n0 * M0;
    assign w_r0 = r_n0b - NW'(r_q0e) * NW'(e2q_pkg::TURN_DIV);
    assign w_hm = (w_r0 >= NW'(e2q_pkg::TURN_DIV)) ? w_r0 - NW'(e2q_pkg::TURN_DIV) : w_r0;

    assign w_p1  = r_n1[32:16] * e2q_pkg::DIV_M1;
    assign w_r1  = r_n1b[32:16] - 17'(r_q1e) * 17'(e2q_pkg::TURN_DIV);
    assign w_r1f = (w_r1 >= 17'(e2q_pkg::TURN_DIV)) ? w_r1 - 17'(e2q_pkg::TURN_DIV) : w_r1;
    assign w_q1  = (w_r1 >= 17'(e2q_pkg::TURN_DIV)) ? r_q1e + 12'd1 : r_q1e;

    assign w_p2  = r_n2 * e2q_pkg::DIV_M2;
    assign w_r2  = r_n2b - 22'(r_q2e) * 22'(e2q_pkg::TURN_DIV);
    assign w_r2f = (w_r2 >= 22'(e2q_pkg::TURN_DIV)) ? w_r2 - 22'(e2q_pkg::TURN_DIV) : w_r2;
    assign w_q2  = (w_r2 >= 22'(e2q_pkg::TURN_DIV)) ? r_q2e + 17'd1 : r_q2e;

    always_ff @(posedge i_clk) begin
        if (i_ld[e2q_pkg::ST_SPLIT]) begin
            r_n0  <= {{5{i_angle[31]}}, i_angle[31:SH]} + OFS;
            r_lo0 <= i_angle[SH-1:0];
        end
        if (i_ld[e2q_pkg::ST_MODEST]) begin
            r_q0e <= w_p0[2*NW-6:NW];
            r_n0b <= r_n0;
            r_lo1 <= r_lo0;
        end
        if (i_ld[e2q_pkg::ST_MODFIX]) begin
            r_hm2 <= w_hm[5:0];
            r_lo2 <= r_lo1;
        end
        if (i_ld[e2q_pkg::ST_PHASEHI]) begin
            r_n1  <= 33'(r_hm2) * 33'(e2q_pkg::TURN_REM) + 33'({r_lo2, {LOW{1'b0}}});
            r_hm3 <= r_hm2;
        end
        if (i_ld[e2q_pkg::ST_DIVA_EST]) begin
            r_q1e <= w_p1[28:17];
            r_n1b <= r_n1;
            r_hm4 <= r_hm3;
        end
        if (i_ld[e2q_pkg::ST_DIVA_FIX]) begin
            r_q1  <= w_q1;
            r_n2  <= {w_r1f[5:0], r_n1b[15:0]};
            r_hm5 <= r_hm4;
        end
        if (i_ld[e2q_pkg::ST_DIVB_EST]) begin
            r_q2e <= w_p2[38:22];
            r_n2b <= r_n2;
            r_q1b <= r_q1;
            r_hq  <= 32'(r_hm5) * e2q_pkg::DIV_Q;
        end
        if (i_ld[e2q_pkg::ST_PHASE]) begin
            r_p <= r_hq + {4'b0, r_q1b, w_q2[15:0]};
        end
    end

    // Phase to radians, then the two sine arguments.
    logic [60:0] w_pu;
    logic [30:0] r_u;
    logic [30:0] r_x0 [2];
    logic [30:0] r_x1 [2];
    logic [31:0] r_x2 [2];
    logic [61:0] w_xx [2];

    assign w_pu = r_p[29:0] * e2q_pkg::HALFPI_Q30;
    assign w_xx[0] = r_x0[0] * r_x0[0];
    assign w_xx[1] = r_x0[1] * r_x0[1];

    always_ff @(posedge i_clk) begin
        if (i_ld[e2q_pkg::ST_RAD]) begin
            r_u <= w_pu[60:30];
            r_quad[e2q_pkg::ST_RAD] <= r_p[31:30];
        end
        for (int j = e2q_pkg::ST_RAD + 1; j < e2q_pkg::ST_MAP; j++) begin
            if (i_ld[j]) begin
                r_quad[j] <= r_quad[j-1];
            end
        end
        if (i_ld[e2q_pkg::ST_COMP]) begin
            r_x0[0] <= r_u;
            r_x0[1] <= e2q_pkg::HALFPI_Q30 - r_u;
        end
        if (i_ld[e2q_pkg::ST_SQR]) begin
            for (int c = 0; c < 2; c++) begin
                r_x1[c] <= r_x0[c];
                r_x2[c] <= w_xx[c][61:30];
            end
        end
    end

    // Horner steps of the sine series, three stages per term.
    logic [30:0] w_ix  [0:NI][2];
    logic [31:0] w_ix2 [0:NI][2];
    logic [30:0] w_is  [0:NI][2];

    for (genvar c = 0; c < 2; c++) begin : g_seed
        assign w_ix[0][c]  = r_x1[c];
        assign w_ix2[0][c] = r_x2[c];
        assign w_is[0][c]  = e2q_pkg::Q30_ONE;
    end

    for (genvar it = 0; it < NI; it++) begin : g_term
        localparam int K  = NI - it;
        localparam int SA = e2q_pkg::ST_ITER + 3 * it;
        localparam logic [7:0]  DEN  = 8'(2 * K * (2 * K + 1));
        localparam logic [31:0] MREC = 32'((64'd1 << 32) / DEN);

        logic [30:0] r_ax [2];
        logic [31:0] r_ax2 [2];
        logic [31:0] r_t [2];
        logic [30:0] r_bx [2];
        logic [31:0] r_bx2 [2];
        logic [31:0] r_bt [2];
        logic [31:0] r_bq [2];
        logic [30:0] r_cx [2];
        logic [31:0] r_cx2 [2];
        logic [30:0] r_cs [2];
        logic [62:0] w_ta [2];
        logic [63:0] w_tb [2];
        logic [31:0] w_rc [2];
        logic [31:0] w_q [2];

        always_comb begin
            for (int c = 0; c < 2; c++) begin
                w_ta[c] = w_ix2[it][c] * w_is[it][c];
                w_tb[c] = r_t[c] * MREC;
                w_rc[c] = r_bt[c] - r_bq[c] * 32'(DEN);
                w_q[c]  = (w_rc[c] >= 32'(DEN)) ? r_bq[c] + 32'd1 : r_bq[c];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int c = 0; c < 2; c++) begin
                if (i_ld[SA]) begin
                    r_ax[c]  <= w_ix[it][c];
                    r_ax2[c] <= w_ix2[it][c];
                    r_t[c]   <= w_ta[c][61:30];
                end
                if (i_ld[SA+1]) begin
                    r_bx[c]  <= r_ax[c];
                    r_bx2[c] <= r_ax2[c];
                    r_bt[c]  <= r_t[c];
                    r_bq[c]  <= w_tb[c][63:32];
                end
                if (i_ld[SA+2]) begin
                    r_cx[c]  <= r_bx[c];
                    r_cx2[c] <= r_bx2[c];
                    r_cs[c]  <= e2q_pkg::Q30_ONE - w_q[c][30:0];
                end
            end
        end

        for (genvar c = 0; c < 2; c++) begin : g_link
            assign w_ix[it+1][c]  = r_cx[c];
            assign w_ix2[it+1][c] = r_cx2[c];
            assign w_is[it+1][c]  = r_cs[c];
        end
    end

    // Final multiply by the argument.
    logic [61:0] w_sp [2];
    logic [30:0] r_sin [2];

    assign w_sp[0] = w_ix[NI][0] * w_is[NI][0];
    assign w_sp[1] = w_ix[NI][1] * w_is[NI][1];

    always_ff @(posedge i_clk) begin
        if (i_ld[e2q_pkg::ST_SIN]) begin
            r_sin[0] <= w_sp[0][60:30];
            r_sin[1] <= w_sp[1][60:30];
        end
    end

    // Quadrant fold and placement on the rotation axis.
    logic signed [31:0] w_s0, w_c0, w_sn, w_cs;
    e2q_pkg::t_quat     w_q, r_q;

    assign w_s0 = signed'({1'b0, r_sin[0]});
    assign w_c0 = signed'({1'b0, r_sin[1]});

    always_comb begin
        case (r_quad[e2q_pkg::ST_MAP-1])
            2'd0: begin
                w_sn = w_s0;
                w_cs = w_c0;
            end
            2'd1: begin
                w_sn = w_c0;
                w_cs = -w_s0;
            end
            2'd2: begin
                w_sn = -w_s0;
                w_cs = -w_c0;
            end
            default: begin
                w_sn = -w_c0;
                w_cs = w_s0;
            end
        endcase
    end

    always_comb begin
        w_q = '0;
        case (r_axis[e2q_pkg::ST_MAP-1])
            e2q_pkg::AXIS_X: begin
                w_q.w = w_cs;
                w_q.x = w_sn;
            end
            e2q_pkg::AXIS_Y: begin
                w_q.w = w_cs;
                w_q.y = w_sn;
            end
            e2q_pkg::AXIS_Z: begin
                w_q.w = w_cs;
                w_q.z = w_sn;
            end
            default: begin
                w_q.w = signed'({1'b0, e2q_pkg::Q30_ONE});
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[e2q_pkg::ST_MAP]) begin
            r_q <= w_q;
        end
    end

    assign o_quat = r_q;

endmodule

### hdl/euler_to_quaternion_core.sv
// Top level of the Euler-to-quaternion core: three angle lanes and the quaternion product.
//
// Input channel: i_valid/o_ready carries three angles in degrees (signed, ANGLE_FRAC_BITS
// fraction bits) and three axis codes (X, Y, Z, or identity). Output channel:
// o_valid/i_ready carries the product q1*q2*q3 as w, x, y, z with QUAT_FRAC_BITS
// fraction bits, saturated to plus or minus one.
// The core is a 42-stage pipeline, and a new beat can enter every cycle while the
// output is not stalled.
// The stage count is set by the sine series: seven Horner terms, each a multiply,
// a reciprocal multiply and a remainder fix, in each angle lane.
// Every stage carries a valid bit. A stage takes new data when it is empty or when the
// stage after it moves, so bubbles close up while the receiver stalls and o_ready
// drops only once all stages hold beats. No beat is lost or repeated.
// Reset clears the valid bits; the data registers are not reset. The core keeps no
// state between beats.
module euler_to_quaternion_core #(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int QUAT_FRAC_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [31:0]              i_first_angle,
    input  logic signed [31:0]              i_second_angle,
    input  logic signed [31:0]              i_third_angle,
    input  logic [1:0]                      i_first_axis,
    input  logic [1:0]                      i_second_axis,
    input  logic [1:0]                      i_third_axis,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [QUAT_FRAC_BITS+1:0] o_quat_w,
    output logic signed [QUAT_FRAC_BITS+1:0] o_quat_x,
    output logic signed [QUAT_FRAC_BITS+1:0] o_quat_y,
    output logic signed [QUAT_FRAC_BITS+1:0] o_quat_z
);

    localparam int OW    = QUAT_FRAC_BITS + 2;
    localparam int LS    = e2q_pkg::LANE_STAGES;
    localparam int ST_HA = LS;
    localparam int ST_O1 = ST_HA + 6;
    localparam int ST_O2 = ST_O1 + 1;
    localparam int NSTG  = ST_O2 + 1;
    localparam int SH    = 30 - QUAT_FRAC_BITS;
    localparam logic [33:0] RND = (34'd1 << SH) >> 1;
    localparam logic [33:0] LIM = 34'd1 << QUAT_FRAC_BITS;

    // Valid bits and the stage-by-stage ready chain.
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_rdy;

    always_comb begin
        w_rdy[NSTG-1] = ~r_v[NSTG-1] | i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = ~r_v[k] | w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NSTG-1];

    // Three angle lanes.
    e2q_pkg::t_quat w_lq [3];

    e2q_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane0 (
        .i_clk   (i_clk),
        .i_ld    (w_rdy[LS-1:0]),
        .i_angle (i_first_angle),
        .i_axis  (i_first_axis),
        .o_quat  (w_lq[0])
    );

    e2q_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane1 (
        .i_clk   (i_clk),
        .i_ld    (w_rdy[LS-1:0]),
        .i_angle (i_second_angle),
        .i_axis  (i_second_axis),
        .o_quat  (w_lq[1])
    );

    e2q_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane2 (
        .i_clk   (i_clk),
        .i_ld    (w_rdy[LS-1:0]),
        .i_angle (i_third_angle),
        .i_axis  (i_third_axis),
        .o_quat  (w_lq[2])
    );

    // The third quaternion waits for the first product.
    e2q_pkg::t_quat r_q3d [3];

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_HA]) begin
            r_q3d[0] <= w_lq[2];
        end
        if (w_rdy[ST_HA+1]) begin
            r_q3d[1] <= r_q3d[0];
        end
        if (w_rdy[ST_HA+2]) begin
            r_q3d[2] <= r_q3d[1];
        end
    end

    // Operands of the two Hamilton products.
    e2q_pkg::t_q30 w_ha [2][4];
    e2q_pkg::t_q30 w_hb [2][4];
    e2q_pkg::t_q30 r_hq [2][4];

    assign w_ha[0][0] = 33'(w_lq[0].w);
    assign w_ha[0][1] = 33'(w_lq[0].x);
    assign w_ha[0][2] = 33'(w_lq[0].y);
    assign w_ha[0][3] = 33'(w_lq[0].z);
    assign w_hb[0][0] = 33'(w_lq[1].w);
    assign w_hb[0][1] = 33'(w_lq[1].x);
    assign w_hb[0][2] = 33'(w_lq[1].y);
    assign w_hb[0][3] = 33'(w_lq[1].z);
    assign w_ha[1][0] = r_hq[0][0];
    assign w_ha[1][1] = r_hq[0][1];
    assign w_ha[1][2] = r_hq[0][2];
    assign w_ha[1][3] = r_hq[0][3];
    assign w_hb[1][0] = 33'(r_q3d[2].w);
    assign w_hb[1][1] = 33'(r_q3d[2].x);
    assign w_hb[1][2] = 33'(r_q3d[2].y);
    assign w_hb[1][3] = 33'(r_q3d[2].z);

    // Hamilton product: magnitudes, sixteen products, then rounded terms summed.
    logic [31:0]        r_ma [2][4];
    logic [31:0]        r_mb [2][4];
    logic               r_sa [2][4];
    logic               r_sb [2][4];
    logic [63:0]        r_pm [2][4][4];
    logic               r_pn [2][4][4];
    logic [32:0]        w_aa [2][4];
    logic [32:0]        w_ab [2][4];
    logic [63:0]        w_pr [2][4][4];
    logic signed [35:0] w_tm [2][4][4];
    logic signed [35:0] w_sum [2][4];

    always_comb begin
        for (int h = 0; h < 2; h++) begin
            for (int i = 0; i < 4; i++) begin
                w_aa[h][i] = w_ha[h][i][32] ? 33'(-w_ha[h][i]) : 33'(w_ha[h][i]);
                w_ab[h][i] = w_hb[h][i][32] ? 33'(-w_hb[h][i]) : 33'(w_hb[h][i]);
                w_sum[h][i] = '0;
                for (int j = 0; j < 4; j++) begin
                    w_pr[h][i][j] = r_pm[h][i][j] + 64'(1 << 29);
                    w_tm[h][i][j] = r_pn[h][i][j] ? -signed'({2'b0, w_pr[h][i][j][63:30]})
                                                  : signed'({2'b0, w_pr[h][i][j][63:30]});
                    w_sum[h][i] = w_sum[h][i] + w_tm[h][i][j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int h = 0; h < 2; h++) begin
            for (int i = 0; i < 4; i++) begin
                if (w_rdy[ST_HA + 3*h]) begin
                    r_ma[h][i] <= w_aa[h][i][31:0];
                    r_mb[h][i] <= w_ab[h][i][31:0];
                    r_sa[h][i] <= w_ha[h][i][32];
                    r_sb[h][i] <= w_hb[h][i][32];
                end
                if (w_rdy[ST_HA + 3*h + 1]) begin
                    for (int j = 0; j < 4; j++) begin
                        r_pm[h][i][j] <= r_ma[h][j] * r_mb[h][i ^ j];
                        r_pn[h][i][j] <= r_sa[h][j] ^ r_sb[h][i ^ j] ^ e2q_pkg::hm_neg(i, j);
                    end
                end
                if (w_rdy[ST_HA + 3*h + 2]) begin
                    r_hq[h][i] <= w_sum[h][i][32:0];
                end
            end
        end
    end

    // Output rounding and saturation.
    logic [32:0]          r_om [4];
    logic                 r_os [4];
    logic [33:0]          w_rnd [4];
    logic [33:0]          w_sat [4];
    logic signed [OW-1:0] r_out [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_rnd[i] = ({1'b0, r_om[i]} + RND) >> SH;
            w_sat[i] = (w_rnd[i] > LIM) ? LIM : w_rnd[i];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            if (w_rdy[ST_O1]) begin
                r_om[i] <= r_hq[1][i][32] ? 33'(-r_hq[1][i]) : 33'(r_hq[1][i]);
                r_os[i] <= r_hq[1][i][32];
            end
            if (w_rdy[ST_O2]) begin
                r_out[i] <= r_os[i] ? -signed'(w_sat[i][OW-1:0]) : signed'(w_sat[i][OW-1:0]);
            end
        end
    end

    assign o_quat_w = r_out[0];
    assign o_quat_x = r_out[1];
    assign o_quat_y = r_out[2];
    assign o_quat_z = r_out[3];

endmodule
